/* design/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define CBD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// expression must never be true outside reset
`define CBD_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define CBD_ASSERT(lbl, clk, rst, prop)
`define CBD_NEVER(lbl, clk, rst, expr)
`endif

`endif

/* design/cbd_pkg.sv */
// ---------------------------------------------------------------------------
// cbd_pkg
// Types and codes shared by the circular buffer deque modules.
// ---------------------------------------------------------------------------
package cbd_pkg;

   typedef enum logic [2:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_PEEK_FRONT = 3'd4,
      OP_PEEK_BACK  = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_LOAD
   } state_type;

   localparam logic [4:0] CAP_RESET = 5'd16;

   typedef struct packed {
      logic        [2:0]  operation;
      logic signed [31:0] push_value;
   } req_item_type;

   typedef struct packed {
      logic signed [31:0] read_value;
      logic        [1:0]  status;
      logic        [4:0]  element_count;
      logic               now_empty;
   } rsp_item_type;

   typedef struct packed {
      logic capture;   // latch the incoming item
      logic exec;      // run the operation on the ring
      logic load;      // move the result into the output register
   } ctrl_cmd_type;

endpackage

/* design/cbd_ram.sv */
// ---------------------------------------------------------------------------
// cbd_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ---------------------------------------------------------------------------
module cbd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // read data holds until the next read
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/cbd_ctrl.sv */
// ---------------------------------------------------------------------------
// cbd_ctrl
// Sequencer: capture an item, execute it, then hand the result to the output.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cbd_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output cbd_pkg::ctrl_cmd_type cmd
);

   cbd_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cbd_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         cbd_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = cbd_pkg::ST_EXEC;
            end
         end
         cbd_pkg::ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = cbd_pkg::ST_LOAD;
         end
         cbd_pkg::ST_LOAD: begin
            // wait for the output register to be free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load = 1'b1;
               state_in = cbd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cbd_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.load | (rsp_valid_ff & ~rsp_ready);
   assign req_ready    = (state_ff == cbd_pkg::ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;

   `CBD_ASSERT(a_accept_exec, clock, reset, (req_valid && req_ready) |=> (state_ff == cbd_pkg::ST_EXEC))
   `CBD_ASSERT(a_exec_load, clock, reset, (state_ff == cbd_pkg::ST_EXEC) |=> (state_ff == cbd_pkg::ST_LOAD))
   `CBD_ASSERT(a_load_valid, clock, reset, cmd.load |=> rsp_valid_ff)

endmodule

/* design/cbd_datapath.sv */
// ---------------------------------------------------------------------------
// cbd_datapath
// Ring indices, element count, capacity register, ring RAM and result register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cbd_datapath #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cbd_pkg::ctrl_cmd_type cmd,
   input  cbd_pkg::req_item_type req_item,
   input  logic                  csr_we,
   input  logic [4:0]            csr_wdata,
   output cbd_pkg::rsp_item_type rsp_item
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int AW    = ((IDX_W > 5) ? IDX_W : 5) + 1;

   logic [4:0]            cap_ff, cap_in, cap_eff;
   logic [IDX_W-1:0]      front_ff, front_in;
   logic [4:0]            count_ff, count_in;
   logic [2:0]            op_ff;
   logic [31:0]           val_ff;
   logic                  rd_use_ff, rd_use_in;
   logic [1:0]            status_ff, status_in;
   cbd_pkg::rsp_item_type rsp_ff, rsp_in;

   logic [AW-1:0] cap_a, front_a, count_a;
   logic [AW-1:0] back_sum, back_a, last_sum, last_a, inc_sum, inc_a, dec_a;
   logic          full, empty;

   logic                  ram_we, ram_re;
   logic [IDX_W-1:0]      ram_wa, ram_ra;
   logic [DATA_WIDTH-1:0] ram_wd, ram_rd;

   // register value 0 acts as 1, anything above DEPTH as DEPTH
   always_comb begin
      if (cap_ff == 5'd0) begin
         cap_eff = 5'd1;
      end else if (32'(cap_ff) > DEPTH) begin
         cap_eff = 5'(DEPTH);
      end else begin
         cap_eff = cap_ff;
      end
   end

   assign cap_a   = AW'(cap_eff);
   assign front_a = AW'(front_ff);
   assign count_a = AW'(count_ff);
   assign full    = (count_ff >= cap_eff);
   assign empty   = (count_ff == 5'd0);

   // indices only move by one slot, so one conditional subtract wraps them
   assign back_sum = front_a + count_a;
   assign back_a   = (back_sum >= cap_a) ? back_sum - cap_a : back_sum;
   assign last_sum = front_a + count_a - AW'(1);
   assign last_a   = (last_sum >= cap_a) ? last_sum - cap_a : last_sum;
   assign inc_sum  = front_a + AW'(1);
   assign inc_a    = (inc_sum >= cap_a) ? inc_sum - cap_a : inc_sum;
   assign dec_a    = (front_a == '0) ? cap_a - AW'(1) : front_a - AW'(1);

   assign ram_wd = DATA_WIDTH'(val_ff);

   always_comb begin
      cap_in    = cap_ff;
      front_in  = front_ff;
      count_in  = count_ff;
      status_in = status_ff;
      rd_use_in = rd_use_ff;
      ram_we    = 1'b0;
      ram_wa    = front_ff;
      ram_re    = 1'b0;
      ram_ra    = front_ff;
      if (csr_we) begin
         // a capacity write also empties the deque
         cap_in   = csr_wdata;
         front_in = '0;
         count_in = '0;
      end else if (cmd.exec) begin
         status_in = cbd_pkg::STAT_OK;
         rd_use_in = 1'b0;
         case (op_ff)
            cbd_pkg::OP_PUSH_FRONT: begin
               if (full) begin
                  status_in = cbd_pkg::STAT_FULL;
               end else begin
                  front_in = IDX_W'(dec_a);
                  ram_we   = 1'b1;
                  ram_wa   = IDX_W'(dec_a);
                  count_in = count_ff + 5'd1;
               end
            end
            cbd_pkg::OP_PUSH_BACK: begin
               if (full) begin
                  status_in = cbd_pkg::STAT_FULL;
               end else begin
                  ram_we   = 1'b1;
                  ram_wa   = IDX_W'(back_a);
                  count_in = count_ff + 5'd1;
               end
            end
            cbd_pkg::OP_POP_FRONT, cbd_pkg::OP_PEEK_FRONT: begin
               if (empty) begin
                  status_in = cbd_pkg::STAT_EMPTY;
               end else begin
                  ram_re    = 1'b1;
                  ram_ra    = front_ff;
                  rd_use_in = 1'b1;
                  if (op_ff == cbd_pkg::OP_POP_FRONT) begin
                     front_in = IDX_W'(inc_a);
                     count_in = count_ff - 5'd1;
                  end
               end
            end
            cbd_pkg::OP_POP_BACK, cbd_pkg::OP_PEEK_BACK: begin
               if (empty) begin
                  status_in = cbd_pkg::STAT_EMPTY;
               end else begin
                  ram_re    = 1'b1;
                  ram_ra    = IDX_W'(last_a);
                  rd_use_in = 1'b1;
                  if (op_ff == cbd_pkg::OP_POP_BACK) begin
                     count_in = count_ff - 5'd1;
                  end
               end
            end
            default: begin
               // unknown operation: no change, status ok
            end
         endcase
      end
   end

   always_comb begin
      rsp_in               = rsp_ff;
      rsp_in.read_value    = rd_use_ff ? 32'($signed(ram_rd)) : 32'sd0;
      rsp_in.status        = status_ff;
      rsp_in.element_count = count_ff;
      rsp_in.now_empty     = (count_ff == 5'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= cbd_pkg::CAP_RESET;
         front_ff <= '0;
         count_ff <= '0;
      end else begin
         cap_ff   <= cap_in;
         front_ff <= front_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_item.operation;
         val_ff <= req_item.push_value;
      end
      status_ff <= status_in;
      rd_use_ff <= rd_use_in;
      if (cmd.load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_item = rsp_ff;

   cbd_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (ram_re),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   `CBD_NEVER(a_count_le_cap, clock, reset, count_ff > cap_eff)
   `CBD_NEVER(a_front_lt_cap, clock, reset, front_a >= cap_a)
   `CBD_ASSERT(a_push_grows, clock, reset, (cmd.exec && !csr_we && !full && (op_ff == cbd_pkg::OP_PUSH_FRONT || op_ff == cbd_pkg::OP_PUSH_BACK)) |=> (count_ff == $past(count_ff) + 5'd1))

endmodule

/* design/circular_buffer_deque.sv */
// Sequence: each item is captured, executed and loaded in turn; its result passes
// the registered read of the ring RAM and the output register. A new item is taken
// only once the last one is loaded; a stalled output adds its wait.
// Reset: synchronous; empties the deque and sets the capacity register to 16.
// Ring contents are not cleared; only slots written by a push are ever read.
// ---------------------------------------------------------------------------
// circular_buffer_deque
// Double-ended queue in a ring RAM with a front index and an element count.
// ---------------------------------------------------------------------------
module circular_buffer_deque #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  cbd_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output cbd_pkg::rsp_item_type rsp_item,
   input  logic                  csr_we,
   input  logic [4:0]            csr_wdata
);

   cbd_pkg::ctrl_cmd_type cmd;

   cbd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   cbd_datapath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_item  (req_item),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .rsp_item  (rsp_item)
   );

endmodule

/* tb/sv/circular_buffer_deque_checker.sv */
// ---------------------------------------------------------------------------
// circular_buffer_deque_checker
// Watches the request, response and CSR ports of the deque, keeps its own
// copy of the ring, predicts every response and compares it field by field.
// ---------------------------------------------------------------------------
module circular_buffer_deque_checker
   import cbd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_ready,
   input  req_item_type req_item,
   input  logic         rsp_valid,
   input  logic         rsp_ready,
   input  rsp_item_type rsp_item,
   input  logic         csr_we,
   input  logic [4:0]   csr_wdata,
   output int           fail_count,
   output int           pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RING_SLOTS  = 16;
   localparam int MAX_REPORTS = 60;

   logic [31:0]  ring_copy [RING_SLOTS];
   int unsigned  head_slot;
   int unsigned  fill_count;
   logic [4:0]   cap_setting;
   rsp_item_type due_rsps [$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      if (fail_count < MAX_REPORTS)
         $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
      fail_count++;
   endtask

   // applies one operation to the shadow deque, returns the response it gives
   function automatic rsp_item_type apply_deque_op(input logic [2:0] op,
                                                   input logic [31:0] value);
      rsp_item_type r;
      int unsigned  slots;
      int unsigned  slot;
      slots = (cap_setting == 5'd0) ? 1 :
              (cap_setting > RING_SLOTS) ? RING_SLOTS : int'(cap_setting);
      r = '0;
      r.status = STAT_OK;
      case (op)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (fill_count >= slots) begin
               r.status = STAT_FULL;
            end else if (op == OP_PUSH_FRONT) begin
               head_slot = (head_slot == 0) ? slots - 1 : head_slot - 1;
               ring_copy[head_slot] = value;
               fill_count++;
            end else begin
               ring_copy[(head_slot + fill_count) % slots] = value;
               fill_count++;
            end
         end
         OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
            if (fill_count == 0) begin
               r.status = STAT_EMPTY;
            end else begin
               if (op == OP_POP_FRONT || op == OP_PEEK_FRONT)
                  slot = head_slot;
               else
                  slot = (head_slot + fill_count - 1) % slots;
               r.read_value = ring_copy[slot];
               if (op == OP_POP_FRONT) begin
                  head_slot = (head_slot + 1) % slots;
                  fill_count--;
               end else if (op == OP_POP_BACK) begin
                  fill_count--;
               end
            end
         end
         default: ;  // spare codes leave the deque alone
      endcase
      r.element_count = 5'(fill_count);
      r.now_empty     = (fill_count == 0);
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         head_slot   = 0;
         fill_count  = 0;
         cap_setting = CAP_RESET;
         due_rsps.delete();
      end else begin
         // a response never belongs to the item taken at the same edge
         if (rsp_valid && rsp_ready) begin
            if (due_rsps.size() == 0) begin
               flag_mismatch("response with no item outstanding", rsp_item.read_value, 0);
            end else begin
               want = due_rsps.pop_front();
               if (rsp_item.read_value !== want.read_value)
                  flag_mismatch("read_value", rsp_item.read_value, want.read_value);
               if (rsp_item.status !== want.status)
                  flag_mismatch("status", 32'(rsp_item.status), 32'(want.status));
               if (rsp_item.element_count !== want.element_count)
                  flag_mismatch("element_count", 32'(rsp_item.element_count),
                                32'(want.element_count));
               if (rsp_item.now_empty !== want.now_empty)
                  flag_mismatch("now_empty", 32'(rsp_item.now_empty),
                                32'(want.now_empty));
            end
         end
         if (req_valid && req_ready)
            due_rsps.push_back(apply_deque_op(req_item.operation, req_item.push_value));
         if (csr_we) begin
            cap_setting = csr_wdata;
            head_slot   = 0;
            fill_count  = 0;
         end
      end
      pending_count <= due_rsps.size();
   end

endmodule

/* tb/sv/circular_buffer_deque_test.sv */
// ---------------------------------------------------------------------------
// circular_buffer_deque_test
// Drives push, pop, peek and spare items into the deque under changing
// capacities, with bursty requests and a stalling response side; the checker
// beside the block predicts and compares every response.
// ---------------------------------------------------------------------------
module circular_buffer_deque_test;
   import cbd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int         RANDOM_ITEMS = 1550;
   localparam int         QUIET_LIMIT  = 2000;
   localparam logic [2:0] OP_SPARE_LO  = 3'd6;
   localparam logic [2:0] OP_SPARE_HI  = 3'd7;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_item_type req_item  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_item_type rsp_item;
   logic         csr_we    = 1'b0;
   logic [4:0]   csr_wdata = 5'd0;
   int           fail_count;
   int           pending_count;

   int           burst_left  = 0;
   int           tide_left   = 0;
   bit           filling     = 1'b1;
   int           quiet_cycles = 0;
   int           sink_mode   = 0;
   int           sink_timer  = 0;
   int           sink_hold   = 0;
   logic [4:0]   cap_plan [10] = '{5'd2, 5'd0, 5'd16, 5'd31, 5'd17,
                                   5'd3, 5'd8, 5'd1, 5'd15, 5'd5};

   circular_buffer_deque u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   circular_buffer_deque_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_item      (req_item),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_item      (rsp_item),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // response side: a new stall pattern each time its random timer runs out
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         sink_timer <= 0;
      end else begin
         if (sink_timer == 0) begin
            sink_mode  <= $urandom_range(0, 3);
            sink_timer <= $urandom_range(20, 80);
         end else begin
            sink_timer <= sink_timer - 1;
         end
         case (sink_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            2: rsp_ready <= (sink_timer[1:0] == 2'b00);
            default: begin
               if (sink_hold == 0) begin
                  rsp_ready <= ~rsp_ready;
                  sink_hold <= $urandom_range(1, 20);
               end else begin
                  sink_hold <= sink_hold - 1;
               end
            end
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // one item, with a random gap before each new burst
   task automatic issue_item(input logic [2:0] op, input logic [31:0] value);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
      req_item.operation  <= op;
      req_item.push_value <= value;
      req_valid           <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      burst_left--;
   endtask

   // only written once the deque has nothing in flight
   task automatic set_capacity(input logic [4:0] cap);
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending_count != 0);
      repeat (4) @(posedge clock);
      csr_wdata <= cap;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 11))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'h7FFF_FFFF;
         3: return 32'h8000_0000;
         default: return $urandom();
      endcase
   endfunction

   // alternate fill and drain tides so that both full and empty are reached
   function automatic logic [2:0] pick_op();
      int roll;
      if (tide_left == 0) begin
         filling   = ~filling;
         tide_left = $urandom_range(1, 36);
      end
      tide_left--;
      roll = $urandom_range(0, 99);
      if (roll < 2)
         return $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
      if (roll < 12)
         return $urandom_range(0, 1) ? OP_PEEK_BACK : OP_PEEK_FRONT;
      if (roll < (filling ? 75 : 30))
         return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      return $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
   endfunction

   initial begin
      int items_sent;
      int phase;
      int phase_len;
      items_sent = 0;
      phase      = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // empty deque at reset capacity, then the value extremes
      issue_item(OP_PEEK_FRONT, 32'h1234_5678);
      issue_item(OP_POP_BACK,   32'h0);
      issue_item(OP_POP_FRONT,  32'hFFFF_FFFF);
      issue_item(OP_PEEK_BACK,  32'h0);
      issue_item(OP_PUSH_FRONT, 32'h7FFF_FFFF);
      issue_item(OP_PUSH_BACK,  32'h8000_0000);
      issue_item(OP_PEEK_FRONT, 32'h0);
      issue_item(OP_PEEK_BACK,  32'h0);
      issue_item(OP_SPARE_LO,   32'hFFFF_FFFF);
      issue_item(OP_SPARE_HI,   32'h5A5A_A5A5);
      issue_item(OP_PUSH_FRONT, 32'hFFFF_FFFF);
      issue_item(OP_POP_BACK,   32'h0);
      issue_item(OP_POP_FRONT,  32'h0);
      issue_item(OP_POP_FRONT,  32'h0);
      issue_item(OP_PEEK_FRONT, 32'h0);

      // single slot: full on both ends, then empty at the back
      set_capacity(5'd1);
      issue_item(OP_PUSH_FRONT, 32'h5555_5555);
      issue_item(OP_PUSH_FRONT, 32'hAAAA_AAAA);
      issue_item(OP_PUSH_BACK,  32'h0000_0000);
      issue_item(OP_PEEK_BACK,  32'h0);
      issue_item(OP_POP_BACK,   32'h0);
      issue_item(OP_POP_BACK,   32'h0);

      while (items_sent < RANDOM_ITEMS) begin
         set_capacity(phase < 10 ? cap_plan[phase] : 5'($urandom_range(0, 31)));
         phase_len = $urandom_range(60, 160);
         repeat (phase_len) begin
            issue_item(pick_op(), pick_value());
            items_sent++;
         end
         phase++;
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

/* sim.f */
+incdir+design
design/cbd_pkg.sv
design/cbd_ram.sv
design/cbd_ctrl.sv
design/cbd_datapath.sv
design/circular_buffer_deque.sv
tb/sv/circular_buffer_deque_checker.sv
tb/sv/circular_buffer_deque_test.sv
